// ===== hw/rtl/rlti_pkg.sv =====
// ----------------------------------------------------------------------------
// rlti_pkg
// Shared types, character codes and helper functions for the radix literal
// to integer block.
// ----------------------------------------------------------------------------
package rlti_pkg;

	// literal kind, settled by the first byte
	typedef enum logic [1:0] {
		MODE_EMPTY,
		MODE_RUN,
		MODE_QUOTE,
		MODE_NONE
	} mode_t;

	// escape sequence tracking inside a quoted literal
	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_SLASH,
		ESC_HEX
	} esc_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_DIGIT  = 3'd1,
		ST_BAD_SUFFIX = 3'd2,
		ST_OPEN_QUOTE = 3'd3,
		ST_BAD_ESC    = 3'd4,
		ST_NO_LIT     = 3'd5
	} status_t;

	// quoted-literal unit towards the top level
	typedef struct packed {
		logic [63:0] value;   // packed characters after this byte
		logic        esc_ok;  // no bad escape so far
		logic        closes;  // this byte is the closing quote
	} rlti_quote_t;

	// accumulator lanes
	localparam int ACC_HEX0 = 0;  // hex from byte 0
	localparam int ACC_HEX2 = 1;  // hex from byte 2 (after 0x)
	localparam int ACC_BIN  = 2;
	localparam int ACC_OCT0 = 3;  // octal from byte 0
	localparam int ACC_OCT1 = 4;  // octal after the leading 0
	localparam int ACC_DEC  = 5;
	localparam int ACC_N    = 6;

	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_1      = 8'h31;
	localparam logic [7:0] CH_7      = 8'h37;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_H      = 8'h68;
	localparam logic [7:0] CH_I      = 8'h69;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_O      = 8'h6F;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_Z      = 8'h7A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return ((c >= CH_UA) && (c <= CH_UZ)) ? (c | 8'h20) : c;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		logic [7:0] l;
		l = to_lower(c);
		return is_digit(c) || ((l >= CH_A) && (l <= CH_Z));
	endfunction

	// 0..15 for a hex digit, bit 4 set otherwise
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] l;
		l = to_lower(c);
		if (is_digit(c))
			return 5'(c - CH_0);
		else if ((l >= CH_A) && (l <= CH_F))
			return 5'(l - CH_A + 8'd10);
		else
			return 5'd16;
	endfunction

endpackage

// ===== hw/rtl/rlti_quote.sv =====
// ----------------------------------------------------------------------------
// rlti_quote
// Quoted literal unit: packs characters base 256 and decodes escapes.
// ----------------------------------------------------------------------------
module rlti_quote
	import rlti_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,   // byte inside the quotes, after the opening one
	input  logic        clear,  // literal finished
	input  logic [7:0]  b,
	output rlti_quote_t q
);

	logic [63:0] char_q;
	logic        esc_ok_q;
	esc_t        phase_q;
	logic [3:0]  nib_q;

	esc_t        phase_n;
	logic [3:0]  nib_n;
	logic        esc_ok_n;
	logic        push;
	logic [7:0]  push_byte;
	logic        plain;
	logic        closes;
	logic [4:0]  hv;

	assign hv = hex_val(b);

	// next escape phase
	always_comb begin
		phase_n  = phase_q;
		nib_n    = nib_q;
		esc_ok_n = esc_ok_q;
		plain    = 1'b0;
		if (step) begin
			unique case (phase_q)
				ESC_NONE: begin
					plain = 1'b1;
				end
				ESC_SLASH: begin
					phase_n = ESC_NONE;
					if (!hv[4]) begin
						nib_n   = hv[3:0];
						phase_n = ESC_HEX;
					end else if (!((b == CH_T) || (b == CH_N) || (b == CH_R) ||
							(b == CH_BSLASH) || (b == CH_DQUOTE))) begin
						esc_ok_n = 1'b0;
					end
				end
				ESC_HEX: begin
					phase_n = ESC_NONE;
					if (hv[4]) begin
						// not a hex digit: flagged, then taken as a plain byte
						esc_ok_n = 1'b0;
						plain    = 1'b1;
					end
				end
				default: begin
					phase_n = ESC_NONE;
				end
			endcase
			if (plain && (b == CH_BSLASH))
				phase_n = ESC_SLASH;
		end
	end

	// character output
	always_comb begin
		push      = 1'b0;
		push_byte = b;
		closes    = 1'b0;
		if (step) begin
			unique case (phase_q)
				ESC_SLASH: begin
					if (hv[4]) begin
						push = (b == CH_T) || (b == CH_N) || (b == CH_R) ||
							(b == CH_BSLASH) || (b == CH_DQUOTE);
						if (b == CH_T)
							push_byte = CH_TAB;
						else if (b == CH_N)
							push_byte = CH_LF;
						else if (b == CH_R)
							push_byte = CH_CR;
					end
				end
				ESC_HEX: begin
					if (!hv[4]) begin
						push      = 1'b1;
						push_byte = {nib_q, hv[3:0]};
					end
				end
				default: begin
				end
			endcase
			if (plain) begin
				if (b == CH_DQUOTE)
					closes = 1'b1;
				else if (b != CH_BSLASH)
					push = 1'b1;
			end
		end
	end

	assign q.value  = push ? {char_q[55:0], push_byte} : char_q;
	assign q.esc_ok = esc_ok_n;
	assign q.closes = closes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_q   <= '0;
			esc_ok_q <= 1'b1;
			phase_q  <= ESC_NONE;
			nib_q    <= '0;
		end else if (clear) begin
			char_q   <= '0;
			esc_ok_q <= 1'b1;
			phase_q  <= ESC_NONE;
			nib_q    <= '0;
		end else begin
			char_q   <= q.value;
			esc_ok_q <= esc_ok_n;
			phase_q  <= phase_n;
			nib_q    <= nib_n;
		end
	end

endmodule

// ===== hw/rtl/radix_literal_to_integer.sv =====
// ----------------------------------------------------------------------------
// radix_literal_to_integer
// Parses one numeric or quoted literal, one byte per transaction, into a
// signed 64-bit value with a status code and a consumed-length count.
// ----------------------------------------------------------------------------
// The block takes one byte per clock: a byte is registered on acceptance,
// and from that input register a single pass updates all six radix
// accumulators (hex, hex after 0x, binary, octal, octal after a leading 0,
// decimal) together with the quoted-string packer, each a shift-and-add of
// one byte's digit. The result of a literal is registered on the output at
// the same edge at which its final byte leaves the input register, and the
// next literal's first byte may follow straight away. The input stalls only
// while a final byte waits behind a result that the receiver has not yet
// taken. Base is chosen at the end: 0x prefix or h suffix gives hex, b or i
// suffix binary, a leading 0 or o suffix octal, otherwise decimal. Every
// error status returns value and consumed as zero.
// ----------------------------------------------------------------------------
module radix_literal_to_integer
	import rlti_pkg::*;
#(
	parameter int MAX_LEN = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_byte,
	input  logic               is_final,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] value,
	output logic [2:0]         status,
	output logic [6:0]         consumed
);

	// consumed count saturates at MAX_LEN, never above what 7 bits hold
	localparam logic [6:0] CONS_CAP = 7'((MAX_LEN < 127) ? MAX_LEN : 127);

	// ---- input register ----
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;

	// ---- literal state ----
	mode_t       mode_q;
	logic        closed_q;     // run ended or closing quote seen
	logic [6:0]  count_q;
	logic [7:0]  f0_q, f1_q;   // first two bytes
	logic [7:0]  last_q;       // newest run byte, possibly a suffix
	logic [63:0] acc_q [ACC_N];
	logic [ACC_N-1:0] ok_q;
	// suffix forms read the sums without the last byte
	logic [63:0] prev_hex0_q, prev_bin_q, prev_oct0_q;
	logic        okp_hex0_q, okp_bin_q, okp_oct0_q;

	// ---- output register ----
	logic signed [63:0] value_q;
	status_t            status_q;
	logic [6:0]         consumed_q;

	// ---- handshake ----
	logic accept, go, clear, out_free;

	assign out_free = !out_valid || !out_stall;
	assign go       = valid_s1 && (!final_s1 || out_free);
	assign clear    = go && final_s1;
	assign in_stall = valid_s1 && !go;
	assign accept   = in_valid && !in_stall;

	// ---- per-byte decode ----
	mode_t      mode_eff;
	logic       b_alnum;
	logic [4:0] hv;
	logic [3:0] dig;
	logic       run_step, quote_step, any_step;
	logic [63:0] upd [ACC_N];
	logic [ACC_N-1:0] dok, lane_en;

	assign b_alnum = is_alnum(byte_s1);
	assign hv      = hex_val(byte_s1);
	assign dig     = is_digit(byte_s1) ? 4'(byte_s1 - CH_0) : 4'd0;

	// literal kind: fixed by the first byte
	always_comb begin
		mode_eff = mode_q;
		if (mode_q == MODE_EMPTY) begin
			if (b_alnum)
				mode_eff = MODE_RUN;
			else if (byte_s1 == CH_DQUOTE)
				mode_eff = MODE_QUOTE;
			else
				mode_eff = MODE_NONE;
		end
	end

	assign run_step   = go && (mode_eff == MODE_RUN) && !closed_q && b_alnum;
	assign quote_step = go && (mode_eff == MODE_QUOTE) && !closed_q;
	assign any_step   = run_step || quote_step;

	// one shift-and-add per lane
	always_comb begin
		upd[ACC_HEX0] = {acc_q[ACC_HEX0][59:0], 4'd0} + 64'(hv[3:0]);
		upd[ACC_HEX2] = {acc_q[ACC_HEX2][59:0], 4'd0} + 64'(hv[3:0]);
		upd[ACC_BIN]  = {acc_q[ACC_BIN][62:0], 1'b0} + 64'(dig[0]);
		upd[ACC_OCT0] = {acc_q[ACC_OCT0][60:0], 3'd0} + 64'(dig[2:0]);
		upd[ACC_OCT1] = {acc_q[ACC_OCT1][60:0], 3'd0} + 64'(dig[2:0]);
		upd[ACC_DEC]  = {acc_q[ACC_DEC][60:0], 3'd0} + {acc_q[ACC_DEC][62:0], 1'b0}
			+ 64'(dig);
		dok[ACC_HEX0] = !hv[4];
		dok[ACC_HEX2] = !hv[4];
		dok[ACC_BIN]  = (byte_s1 == CH_0) || (byte_s1 == CH_1);
		dok[ACC_OCT0] = (byte_s1 >= CH_0) && (byte_s1 <= CH_7);
		dok[ACC_OCT1] = dok[ACC_OCT0];
		dok[ACC_DEC]  = is_digit(byte_s1);
		lane_en       = {ACC_N{run_step}};
		// 0x lane starts at byte 2, leading-0 octal lane at byte 1
		lane_en[ACC_HEX2] = run_step && (count_q >= 7'd2);
		lane_en[ACC_OCT1] = run_step && (count_q >= 7'd1);
	end

	// ---- next state, before the end-of-literal clear ----
	logic [63:0] acc_n [ACC_N];
	logic [ACC_N-1:0] ok_n;
	logic [63:0] prev_hex0_n, prev_bin_n, prev_oct0_n;
	logic        okp_hex0_n, okp_bin_n, okp_oct0_n;
	logic [6:0]  count_n;
	logic [7:0]  f0_n, f1_n, last_n;
	logic        closed_n;
	rlti_quote_t qt;

	always_comb begin
		for (int k = 0; k < ACC_N; k++) begin
			acc_n[k] = lane_en[k] ? upd[k] : acc_q[k];
			ok_n[k]  = lane_en[k] ? (ok_q[k] & dok[k]) : ok_q[k];
		end
		prev_hex0_n = run_step ? acc_q[ACC_HEX0] : prev_hex0_q;
		prev_bin_n  = run_step ? acc_q[ACC_BIN]  : prev_bin_q;
		prev_oct0_n = run_step ? acc_q[ACC_OCT0] : prev_oct0_q;
		okp_hex0_n  = run_step ? ok_q[ACC_HEX0]  : okp_hex0_q;
		okp_bin_n   = run_step ? ok_q[ACC_BIN]   : okp_bin_q;
		okp_oct0_n  = run_step ? ok_q[ACC_OCT0]  : okp_oct0_q;
		count_n     = (any_step && (count_q != 7'd127)) ? count_q + 7'd1 : count_q;
		f0_n        = (run_step && (count_q == 7'd0)) ? byte_s1 : f0_q;
		f1_n        = (run_step && (count_q == 7'd1)) ? byte_s1 : f1_q;
		last_n      = run_step ? byte_s1 : last_q;
		closed_n    = closed_q
			|| (go && (mode_eff == MODE_RUN) && !closed_q && !b_alnum)
			|| qt.closes;
	end

	rlti_quote u_quote (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (quote_step && (count_q != 7'd0)),
		.clear  (clear),
		.b      (byte_s1),
		.q      (qt)
	);

	// ---- end-of-literal evaluation ----
	logic [63:0] res_val;
	status_t     res_st;
	logic [7:0]  ll, f1l;
	logic        ok;

	always_comb begin
		ll      = to_lower(last_n);
		f1l     = to_lower(f1_n);
		res_val = '0;
		ok      = 1'b0;
		res_st  = ST_OK;
		unique case (mode_eff)
			MODE_RUN: begin
				if ((count_n > 7'd2) && (f0_n == CH_0) && (f1l == CH_X)) begin
					res_val = acc_n[ACC_HEX2];
					ok      = ok_n[ACC_HEX2];
				end else if (ll == CH_H) begin
					res_val = prev_hex0_n;
					ok      = okp_hex0_n;
				end else if ((count_n > 7'd1) && ((ll == CH_B) || (ll == CH_I))) begin
					res_val = prev_bin_n;
					ok      = okp_bin_n;
				end else if ((count_n > 7'd1) && (f0_n == CH_0)) begin
					res_val = acc_n[ACC_OCT1];
					ok      = ok_n[ACC_OCT1];
				end else if ((count_n > 7'd1) && (ll == CH_O)) begin
					res_val = prev_oct0_n;
					ok      = okp_oct0_n;
				end else if (!is_digit(ll)) begin
					ok = 1'b1;  // status carries the error
				end else begin
					res_val = acc_n[ACC_DEC];
					ok      = ok_n[ACC_DEC];
				end
				if (!((count_n > 7'd2) && (f0_n == CH_0) && (f1l == CH_X)) &&
						(ll != CH_H) &&
						!((count_n > 7'd1) && ((ll == CH_B) || (ll == CH_I) ||
						(f0_n == CH_0) || (ll == CH_O))) &&
						!is_digit(ll))
					res_st = ST_BAD_SUFFIX;
				else if (!ok)
					res_st = ST_BAD_DIGIT;
			end
			MODE_QUOTE: begin
				res_val = qt.value;
				if (!closed_n)
					res_st = ST_OPEN_QUOTE;
				else if (!qt.esc_ok)
					res_st = ST_BAD_ESC;
			end
			default: begin
				res_st = ST_NO_LIT;
			end
		endcase
	end

	// ---- registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
			final_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				byte_s1  <= char_byte;
				final_s1 <= is_final;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_EMPTY;
			closed_q    <= 1'b0;
			count_q     <= '0;
			f0_q        <= '0;
			f1_q        <= '0;
			last_q      <= '0;
			ok_q        <= '1;
			prev_hex0_q <= '0;
			prev_bin_q  <= '0;
			prev_oct0_q <= '0;
			okp_hex0_q  <= 1'b1;
			okp_bin_q   <= 1'b1;
			okp_oct0_q  <= 1'b1;
			for (int k = 0; k < ACC_N; k++)
				acc_q[k] <= '0;
		end else if (clear) begin
			mode_q      <= MODE_EMPTY;
			closed_q    <= 1'b0;
			count_q     <= '0;
			f0_q        <= '0;
			f1_q        <= '0;
			last_q      <= '0;
			ok_q        <= '1;
			prev_hex0_q <= '0;
			prev_bin_q  <= '0;
			prev_oct0_q <= '0;
			okp_hex0_q  <= 1'b1;
			okp_bin_q   <= 1'b1;
			okp_oct0_q  <= 1'b1;
			for (int k = 0; k < ACC_N; k++)
				acc_q[k] <= '0;
		end else if (go) begin
			mode_q      <= mode_eff;
			closed_q    <= closed_n;
			count_q     <= count_n;
			f0_q        <= f0_n;
			f1_q        <= f1_n;
			last_q      <= last_n;
			ok_q        <= ok_n;
			prev_hex0_q <= prev_hex0_n;
			prev_bin_q  <= prev_bin_n;
			prev_oct0_q <= prev_oct0_n;
			okp_hex0_q  <= okp_hex0_n;
			okp_bin_q   <= okp_bin_n;
			okp_oct0_q  <= okp_oct0_n;
			for (int k = 0; k < ACC_N; k++)
				acc_q[k] <= acc_n[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (clear) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (clear) begin
			status_q   <= res_st;
			value_q    <= (res_st == ST_OK) ? res_val : '0;
			consumed_q <= (res_st != ST_OK) ? 7'd0 :
				((count_n < CONS_CAP) ? count_n : CONS_CAP);
		end
	end

	assign value    = value_q;
	assign status   = status_q;
	assign consumed = consumed_q;

	// ---- checks ----
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (value == '0) && (consumed == 7'd0))
		else $error("error result carries a value or length");

	a_cons_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> consumed <= CONS_CAP)
		else $error("consumed count beyond its cap");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && final_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked final byte");

	a_none_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_NONE) || (mode_q == MODE_EMPTY) |-> count_q == 7'd0)
		else $error("bytes counted outside a literal");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (mode_q == MODE_EMPTY) && (count_q == 7'd0) && out_valid)
		else $error("literal state not cleared after its final byte");

endmodule

// ===== bench/tb_radix_literal_to_integer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix_literal_to_integer
// Drives byte streams of numeric and quoted literals into the parser and
// checks every result transaction against a cycle-free predictor. Directed
// literals cover each base, suffix, escape and error status. Random literals
// are mostly well-formed with random content, plus noise and broken ones,
// under three idling patterns on the two channels.
// ----------------------------------------------------------------------------
module tb_radix_literal_to_integer
	import rlti_pkg::*;
();

	localparam int         MAX_LEN     = 64;
	localparam logic [6:0] LEN_CAP     = (MAX_LEN < 127) ? 7'(MAX_LEN) : 7'd127;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         TAIL_CYCLES = 20;

	localparam string HEX_SET  = "0123456789abcdefABCDEF";
	localparam string BIN_SET  = "01";
	localparam string OCT_SET  = "01234567";
	localparam string DEC_SET  = "0123456789";
	localparam string WORD_SET =
		"0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";

	typedef struct {
		logic signed [63:0] value;
		status_t            status;
		logic [6:0]         consumed;
	} lit_result_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic [7:0]         char_byte = 8'h00;
	logic               is_final  = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [63:0] value;
	logic [2:0]         status;
	logic [6:0]         consumed;

	radix_literal_to_integer #(
		.MAX_LEN(MAX_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_byte(char_byte),
		.is_final(is_final),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value),
		.status(status),
		.consumed(consumed)
	);

	// results predicted but not yet seen on the output
	lit_result_t pending_results[$];
	lit_result_t want;
	int          mismatch_count = 0;
	int          cycle_count    = 0;
	int          tx_idle_pct    = 0;
	int          rx_idle_pct    = 0;

	// literal under construction by the random generator
	logic [7:0] literal_q[$];
	int         body_len;

	// ------------------------------------------------------------------
	// Predictor state: one literal in flight
	// ------------------------------------------------------------------
	mode_t             lit_kind;
	logic [6:0]        lit_len;
	logic [7:0]        lead0, lead1;
	logic [63:0]       lane_sum[ACC_N];
	logic [ACC_N-1:0]  lane_ok;
	logic              esc_ok;
	logic [63:0]       packed_chars;
	esc_t              esc_state;
	logic [3:0]        esc_nib;
	logic              lit_ended;
	logic [7:0]        tail_char;

	function automatic logic dec_char(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
	endfunction

	function automatic logic word_char(input logic [7:0] c);
		return dec_char(c) || (fold_case(c) >= CH_A && fold_case(c) <= CH_Z);
	endfunction

	// bit 4 set when c is no hex digit
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		logic [7:0] l;
		l = fold_case(c);
		if (dec_char(c))
			return 5'(c - CH_0);
		if (l >= CH_A && l <= CH_F)
			return 5'(l - CH_A + 8'd10);
		return 5'd16;
	endfunction

	function automatic void clear_literal();
		lit_kind     = MODE_EMPTY;
		lit_len      = '0;
		lead0        = '0;
		lead1        = '0;
		for (int k = 0; k < ACC_N; k++)
			lane_sum[k] = '0;
		lane_ok      = '1;
		esc_ok       = 1'b1;
		packed_chars = '0;
		esc_state    = ESC_NONE;
		esc_nib      = '0;
		lit_ended    = 1'b0;
		tail_char    = '0;
	endfunction

	// a byte of the run is folded in only once the next one shows it is no suffix
	function automatic void fold_digit(input logic [7:0] c, input logic [6:0] pos);
		logic [4:0] hv;
		logic [7:0] d;
		logic       oct;
		hv  = nibble_of(c);
		d   = dec_char(c) ? c - CH_0 : 8'd0;
		oct = c >= CH_0 && c <= CH_7;
		lane_sum[ACC_HEX0] = lane_sum[ACC_HEX0] * 64'd16 + 64'(hv[3:0]);
		if (hv[4])
			lane_ok[ACC_HEX0] = 1'b0;
		if (pos >= 7'd2) begin
			lane_sum[ACC_HEX2] = lane_sum[ACC_HEX2] * 64'd16 + 64'(hv[3:0]);
			if (hv[4])
				lane_ok[ACC_HEX2] = 1'b0;
		end
		lane_sum[ACC_BIN] = lane_sum[ACC_BIN] * 64'd2 + 64'(d[0]);
		if (c != CH_0 && c != CH_1)
			lane_ok[ACC_BIN] = 1'b0;
		lane_sum[ACC_OCT0] = lane_sum[ACC_OCT0] * 64'd8 + 64'(d[2:0]);
		if (!oct)
			lane_ok[ACC_OCT0] = 1'b0;
		if (pos >= 7'd1) begin
			lane_sum[ACC_OCT1] = lane_sum[ACC_OCT1] * 64'd8 + 64'(d[2:0]);
			if (!oct)
				lane_ok[ACC_OCT1] = 1'b0;
		end
		lane_sum[ACC_DEC] = lane_sum[ACC_DEC] * 64'd10 + 64'(d);
		if (!dec_char(c))
			lane_ok[ACC_DEC] = 1'b0;
	endfunction

	function automatic void plain_quoted(input logic [7:0] c);
		if (c == CH_DQUOTE)
			lit_ended = 1'b1;
		else if (c == CH_BSLASH)
			esc_state = ESC_SLASH;
		else
			packed_chars = {packed_chars[55:0], c};
	endfunction

	function automatic void fold_quoted(input logic [7:0] c);
		logic [4:0] hv;
		hv = nibble_of(c);
		case (esc_state)
			ESC_SLASH: begin
				esc_state = ESC_NONE;
				if (!hv[4]) begin
					esc_nib   = hv[3:0];
					esc_state = ESC_HEX;
				end else if (c == CH_T)
					packed_chars = {packed_chars[55:0], CH_TAB};
				else if (c == CH_N)
					packed_chars = {packed_chars[55:0], CH_LF};
				else if (c == CH_R)
					packed_chars = {packed_chars[55:0], CH_CR};
				else if (c == CH_BSLASH || c == CH_DQUOTE)
					packed_chars = {packed_chars[55:0], c};
				else
					esc_ok = 1'b0;
			end
			ESC_HEX: begin
				esc_state = ESC_NONE;
				if (!hv[4])
					packed_chars = {packed_chars[55:0], esc_nib, hv[3:0]};
				else begin
					// bad second digit is then taken as an ordinary byte
					esc_ok = 1'b0;
					plain_quoted(c);
				end
			end
			default: plain_quoted(c);
		endcase
	endfunction

	// base is settled here: 0x prefix, h, b/i, leading 0, o, then decimal
	function automatic void settle_run(output logic [63:0] v, output status_t st);
		logic [7:0] ll;
		logic [4:0] hv;
		logic       oct;
		logic       ok;
		ll  = fold_case(tail_char);
		hv  = nibble_of(tail_char);
		oct = tail_char >= CH_0 && tail_char <= CH_7;
		v   = '0;
		st  = ST_OK;
		if (lit_len > 7'd2 && lead0 == CH_0 && fold_case(lead1) == CH_X) begin
			v  = lane_sum[ACC_HEX2] * 64'd16 + 64'(hv[3:0]);
			ok = lane_ok[ACC_HEX2] && !hv[4];
		end else if (ll == CH_H) begin
			v  = lane_sum[ACC_HEX0];
			ok = lane_ok[ACC_HEX0];
		end else if (lit_len > 7'd1 && (ll == CH_B || ll == CH_I)) begin
			v  = lane_sum[ACC_BIN];
			ok = lane_ok[ACC_BIN];
		end else if (lit_len > 7'd1 && lead0 == CH_0) begin
			v  = lane_sum[ACC_OCT1] * 64'd8 + (oct ? 64'(tail_char - CH_0) : 64'd0);
			ok = lane_ok[ACC_OCT1] && oct;
		end else if (lit_len > 7'd1 && ll == CH_O) begin
			v  = lane_sum[ACC_OCT0];
			ok = lane_ok[ACC_OCT0];
		end else if (!dec_char(ll)) begin
			st = ST_BAD_SUFFIX;
			return;
		end else begin
			v  = lane_sum[ACC_DEC] * 64'd10 + 64'(tail_char - CH_0);
			ok = lane_ok[ACC_DEC];
		end
		st = ok ? ST_OK : ST_BAD_DIGIT;
	endfunction

	// called once per accepted input transaction
	function automatic void absorb_byte(input logic [7:0] c, input logic fin);
		lit_result_t res;
		logic [63:0] v;
		status_t     st;
		v  = '0;
		st = ST_OK;
		if (lit_kind == MODE_EMPTY)
			lit_kind = word_char(c) ? MODE_RUN : (c == CH_DQUOTE ? MODE_QUOTE : MODE_NONE);
		if (lit_kind == MODE_RUN && !lit_ended) begin
			if (word_char(c)) begin
				if (lit_len != 0)
					fold_digit(tail_char, lit_len - 7'd1);
				if (lit_len == 7'd0)
					lead0 = c;
				else if (lit_len == 7'd1)
					lead1 = c;
				tail_char = c;
				if (lit_len < 7'd127)
					lit_len++;
			end else
				lit_ended = 1'b1;
		end else if (lit_kind == MODE_QUOTE && !lit_ended) begin
			if (lit_len != 0)
				fold_quoted(c);
			if (lit_len < 7'd127)
				lit_len++;
		end
		if (!fin)
			return;
		case (lit_kind)
			MODE_RUN: settle_run(v, st);
			MODE_QUOTE: begin
				if (!lit_ended)
					st = ST_OPEN_QUOTE;
				else if (!esc_ok)
					st = ST_BAD_ESC;
				else
					v = packed_chars;
			end
			default: st = ST_NO_LIT;
		endcase
		res.status   = st;
		res.value    = (st == ST_OK) ? v : 64'd0;
		res.consumed = (st == ST_OK) ? ((lit_len < LEN_CAP) ? lit_len : LEN_CAP) : 7'd0;
		pending_results.push_back(res);
		clear_literal();
	endfunction

	// ------------------------------------------------------------------
	// Clock, watchdog, receiver and result checking
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk) cycle_count++;
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// sampled mid-cycle so that the handshake is settled before the edge
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with none expected: value %0d status %0d consumed %0d",
					$time, value, status, consumed);
			end else begin
				want = pending_results.pop_front();
				if (value !== want.value) begin
					mismatch_count++;
					$display("%0t: value mismatch: expected %0d, actual %0d",
						$time, want.value, value);
				end
				if (status !== want.status) begin
					mismatch_count++;
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, want.status, status);
				end
				if (consumed !== want.consumed) begin
					mismatch_count++;
					$display("%0t: consumed mismatch: expected %0d, actual %0d",
						$time, want.consumed, consumed);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sending
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] c, input logic fin);
		bit took;
		// each cycle idles with the set chance before the byte is offered
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		char_byte <= c;
		is_final  <= fin;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
		absorb_byte(c, fin);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	task automatic send_literal();
		for (int i = 0; i < literal_q.size(); i++)
			send_byte(literal_q[i], i == literal_q.size() - 1);
	endtask

	// sender holds off until every outstanding result has been taken
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Random literal generation
	// ------------------------------------------------------------------
	function automatic logic [7:0] pick(input string set);
		return set[$urandom_range(set.len() - 1)];
	endfunction

	function automatic void add_chars(input string set, input int n);
		for (int i = 0; i < n; i++)
			literal_q.push_back(pick(set));
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		c = 8'($urandom_range(255));
		return (c == CH_DQUOTE || c == CH_BSLASH) ? CH_A : c;
	endfunction

	function automatic void add_quoted(input int n);
		literal_q.push_back(CH_DQUOTE);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: begin
					literal_q.push_back(CH_BSLASH);
					literal_q.push_back(pick("tnr\\\""));
				end
				1: begin
					literal_q.push_back(CH_BSLASH);
					literal_q.push_back(pick(HEX_SET));
					// now and then a broken second digit, the quote among them
					literal_q.push_back(($urandom_range(5) == 0) ? pick("g\"z ") : pick(HEX_SET));
				end
				2: begin
					literal_q.push_back(CH_BSLASH);
					literal_q.push_back(8'($urandom_range(255)));
				end
				default: literal_q.push_back(plain_byte());
			endcase
		end
		if ($urandom_range(7) != 0)
			literal_q.push_back(CH_DQUOTE);
	endfunction

	// mostly well-formed literals of every base, some broken, some noise
	function automatic void make_literal();
		int n;
		literal_q.delete();
		n = ($urandom_range(19) == 0) ? $urandom_range(17, 70) : $urandom_range(1, 8);
		case ($urandom_range(9))
			0: begin
				literal_q.push_back(CH_0);
				literal_q.push_back(pick("xX"));
				add_chars(HEX_SET, n);
			end
			1: begin
				add_chars(HEX_SET, n);
				literal_q.push_back(pick("hH"));
			end
			2: begin
				add_chars(BIN_SET, n);
				literal_q.push_back(pick("bBiI"));
			end
			3: begin
				literal_q.push_back(CH_0);
				add_chars(OCT_SET, n);
			end
			4: begin
				add_chars(OCT_SET, n);
				literal_q.push_back(pick("oO"));
			end
			5: add_chars(DEC_SET, n);
			6, 7: add_quoted(n);
			8: begin
				if ($urandom_range(1)) begin
					literal_q.push_back(CH_0);
					literal_q.push_back(CH_X);
				end
				add_chars(WORD_SET, n);
			end
			default: begin
				for (int i = 0; i < $urandom_range(1, 4); i++)
					literal_q.push_back(8'($urandom_range(255)));
			end
		endcase
		body_len = literal_q.size();
		// ignored bytes after the end of the literal
		if ($urandom_range(7) == 0) begin
			literal_q.push_back(pick(" +-,;)\""));
			for (int i = 0; i < $urandom_range(1, 3); i++)
				literal_q.push_back(8'($urandom_range(255)));
		end
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_number_forms();
		send_text("0x1F");
		send_text("0XfF");
		send_text("ffH");
		send_text("h");                      // empty hex number
		send_text("1011b");
		send_text("110I");
		send_text("0777");
		send_text("17o");
		send_text("18446744073709551615");   // wraps to -1
		send_text("0x");                     // too short for hex, bad octal
		send_text("2b");                     // bad binary digit
		send_text("12z");                    // unknown suffix
		send_text("0");
	endtask

	task automatic test_quoted_strings();
		send_text("\"AB\"");
		send_text("\"\\t\\n\\r\\\\\\\"\"");  // every named escape
		send_text("\"\\41\\fF\"");           // hex pair escapes
		send_text("\"\\q\"");                // bad escape
		send_text("\"\\4\"");                // bad second digit, quote still closes
		send_text("\"\\\\\"");               // quote after an escaped backslash
		send_text("\"ab");                   // no closing quote
		send_text("\"\\4");                  // ends inside an escape
		literal_q = '{CH_DQUOTE, 8'h00, 8'hFF, CH_DQUOTE};
		send_literal();
	endtask

	task automatic test_no_literal_and_trailing();
		send_text("+");
		literal_q = '{8'hFF};
		send_literal();
		send_text("12 34");                  // bytes after the run are ignored
		drain();
		send_text("\"a\"zz");                // and after the closing quote
	endtask

	task automatic test_long_literals();
		literal_q.delete();
		repeat (70) literal_q.push_back(CH_9);
		send_literal();
		literal_q = '{CH_0, CH_X};
		repeat (66) literal_q.push_back(CH_F);
		send_literal();
		literal_q = '{CH_DQUOTE};
		repeat (70) literal_q.push_back(CH_Z);
		literal_q.push_back(CH_DQUOTE);
		send_literal();
	endtask

	task automatic test_random_traffic(input int budget);
		int sent;
		sent = 0;
		while (sent < budget) begin
			make_literal();
			sent += body_len;
			send_literal();
		end
	endtask

	initial begin
		clear_literal();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 11;
		rx_idle_pct = 49;
		test_number_forms();
		test_quoted_strings();
		test_no_literal_and_trailing();
		test_long_literals();
		test_random_traffic(40);
		drain();

		tx_idle_pct = 49;
		rx_idle_pct = 11;
		test_random_traffic(40);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_traffic(40);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
